// ===== rtl/tpsm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpsm_pkg
// Widths, tables and beat types for the tetrahedron stabilization matrix.
// ----------------------------------------------------------------------------
package tpsm_pkg;

	localparam int CW     = 32;            // coordinate, Q15.16
	localparam int DW     = CW + 1;        // coordinate difference
	localparam int PW     = 2 * DW;        // product of two differences
	localparam int SQW    = 2 * CW;        // squared difference
	localparam int NW     = PW + 1;        // face normal component
	localparam int NLW    = 34;            // low split of a normal component
	localparam int NHW    = NW - NLW;      // high split, signed
	localparam int DHW    = DW + NHW;      // det partial, high
	localparam int DLW    = DW + NLW + 1;  // det partial, low
	localparam int DETW   = 101;           // six-fold volume
	localparam int LW     = SQW + 2;       // squared edge length
	localparam int HLW    = 33;            // split of h2 for the weight product
	localparam int SPW    = CW + HLW;      // weight partial product
	localparam int SCW    = CW + LW;       // delta * h2
	localparam int HHW    = 2 * NHW;
	localparam int HLPW   = NHW + NLW + 1;
	localparam int LLW    = 2 * NLW;
	localparam int PCW    = 136;           // one component of a dot product
	localparam int DOTW   = 133;
	localparam int ADW    = DOTW - 1;
	localparam int LIMB   = 32;
	localparam int SCL    = 4;             // limbs of the scale
	localparam int ADL    = 5;             // limbs of |dot|
	localparam int PPW    = 2 * LIMB;
	localparam int ROWW   = PPW + LIMB * (ADL - 1);
	localparam int NUMXW  = ROWW + LIMB * (SCL - 1);
	localparam int NUMW   = 230;
	localparam int NUMERW = NUMW + 2;
	localparam int FRAC   = 32;            // output fraction bits
	localparam int DEN6W  = DETW + 2;
	localparam int DENW   = DEN6W + FRAC;
	localparam int DIVW   = DENW + 1;
	localparam int QW     = 63;            // quotient bits below saturation
	localparam int VALW   = 64;
	localparam int CNT_W  = 4;
	localparam int N_ENTRIES = 16;

	localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(N_ENTRIES - 1);
	localparam logic [CW-1:0]    STAB_RESET = 32'd6554;
	localparam logic [2:0]       DET_SCALE  = 3'd6;
	localparam logic [VALW-1:0]  VAL_MAX    = {1'b0, {(VALW-1){1'b1}}};
	localparam logic [VALW-1:0]  VAL_MIN    = {1'b1, {(VALW-1){1'b0}}};

	// vertices a, b, q of the face opposite each vertex
	localparam logic [1:0] FACE_TAB [4][3] = '{
		'{2'd1, 2'd2, 2'd3}, '{2'd0, 2'd3, 2'd2},
		'{2'd0, 2'd1, 2'd3}, '{2'd0, 2'd2, 2'd1}};
	localparam logic [1:0] PAIR_I [6] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
	localparam logic [1:0] PAIR_J [6] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};

	typedef struct packed {
		logic signed [CW-1:0] v0_x;
		logic signed [CW-1:0] v0_y;
		logic signed [CW-1:0] v0_z;
		logic signed [CW-1:0] v1_x;
		logic signed [CW-1:0] v1_y;
		logic signed [CW-1:0] v1_z;
		logic signed [CW-1:0] v2_x;
		logic signed [CW-1:0] v2_y;
		logic signed [CW-1:0] v2_z;
		logic signed [CW-1:0] v3_x;
		logic signed [CW-1:0] v3_y;
		logic signed [CW-1:0] v3_z;
	} tpsm_in_t;

	typedef struct packed {
		logic [1:0]             row_index;
		logic [1:0]             col_index;
		logic signed [VALW-1:0] entry_value;
		logic                   degenerate;
		logic                   last_entry;
	} tpsm_out_t;

	typedef struct packed {
		logic [1:0] row;
		logic [1:0] col;
		logic       last;
		logic       degen;
		logic       neg;
		logic       big;
	} tpsm_meta_t;

endpackage

// ===== rtl/tpsm_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpsm_in_if
// Vertex channel: valid, ready and one tetrahedron per beat.
// ----------------------------------------------------------------------------
interface tpsm_in_if;
	import tpsm_pkg::*;
	logic     valid;
	logic     ready;
	tpsm_in_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/tpsm_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpsm_out_if
// Matrix entry channel: valid, ready and one entry per beat.
// ----------------------------------------------------------------------------
interface tpsm_out_if;
	import tpsm_pkg::*;
	logic      valid;
	logic      ready;
	tpsm_out_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/tpsm_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpsm_div
// Restoring divider, one quotient bit per pipeline stage, frozen by adv.
// ----------------------------------------------------------------------------
module tpsm_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  logic                       in_valid,
	input  logic [tpsm_pkg::DIVW-1:0]  in_rem,
	input  logic [tpsm_pkg::DIVW-1:0]  in_den,
	input  logic [tpsm_pkg::QW-1:0]    in_low,
	input  tpsm_pkg::tpsm_meta_t       in_meta,
	output logic                       out_valid,
	output logic [tpsm_pkg::QW-1:0]    out_quo,
	output tpsm_pkg::tpsm_meta_t       out_meta
);
	import tpsm_pkg::*;

	logic             v_s    [QW];
	logic [DIVW-1:0]  rem_s  [QW];
	logic [DIVW-1:0]  den_s  [QW];
	logic [QW-1:0]    low_s  [QW];
	logic [QW-1:0]    quo_s  [QW];
	tpsm_meta_t       meta_s [QW];

	logic             src_v    [QW];
	logic [DIVW-1:0]  src_rem  [QW];
	logic [DIVW-1:0]  src_den  [QW];
	logic [QW-1:0]    src_low  [QW];
	logic [QW-1:0]    src_quo  [QW];
	tpsm_meta_t       src_meta [QW];
	logic [DIVW:0]    trial    [QW];
	logic [DIVW:0]    diff     [QW];
	logic             take     [QW];

	always_comb begin
		src_v[0]    = in_valid;
		src_rem[0]  = in_rem;
		src_den[0]  = in_den;
		src_low[0]  = in_low;
		src_quo[0]  = '0;
		src_meta[0] = in_meta;
		for (int k = 1; k < QW; k++) begin
			src_v[k]    = v_s[k-1];
			src_rem[k]  = rem_s[k-1];
			src_den[k]  = den_s[k-1];
			src_low[k]  = low_s[k-1];
			src_quo[k]  = quo_s[k-1];
			src_meta[k] = meta_s[k-1];
		end
		for (int k = 0; k < QW; k++) begin
			// bring down the next numerator bit, subtract when it fits
			trial[k] = {src_rem[k], src_low[k][QW-1]};
			diff[k]  = trial[k] - {1'b0, src_den[k]};
			take[k]  = trial[k] >= {1'b0, src_den[k]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < QW; k++) v_s[k] <= 1'b0;
		end else if (adv) begin
			for (int k = 0; k < QW; k++) v_s[k] <= src_v[k];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < QW; k++) begin
				rem_s[k]  <= take[k] ? diff[k][DIVW-1:0] : trial[k][DIVW-1:0];
				den_s[k]  <= src_den[k];
				low_s[k]  <= src_low[k] << 1;
				quo_s[k]  <= {src_quo[k][QW-2:0], take[k]};
				meta_s[k] <= src_meta[k];
			end
		end
	end

	assign out_valid = v_s[QW-1];
	assign out_quo   = quo_s[QW-1];
	assign out_meta  = meta_s[QW-1];

endmodule

// ===== rtl/tet_pressure_stabilization_matrix_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tet_pressure_stabilization_matrix_top
// P1 tetrahedron pressure stabilization matrix, sixteen entries per element.
// ----------------------------------------------------------------------------
// Path: front end s1-s6, hold register, back end s7-s13, the 63-stage
//   bit-per-stage divider and the output register; entries follow row-major.
// Throughput: one entry per cycle at the entry port while entries.ready is high;
//   the front end takes a new element every cycle while it has room.
// Reset: arst_n clears all valid bits and the hold counter and loads delta
//   with its default; no clearing pass.
module tet_pressure_stabilization_matrix_top (
	input  logic                   clk,
	input  logic                   arst_n,
	tpsm_in_if.sink                vertices,
	tpsm_out_if.source             entries,
	input  logic                   cfg_we,
	input  logic [tpsm_pkg::CW-1:0] cfg_wdata
);
	import tpsm_pkg::*;

	logic [CW-1:0] delta_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delta_q <= STAB_RESET;
		end else if (cfg_we) begin
			delta_q <= cfg_wdata;
		end
	end

	// ---------------- front end: one element per stage ----------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en1, en2, en3, en4, en5, en6;
	logic h_valid_q, h_free, adv;
	logic [CNT_W-1:0] cnt_q;

	assign en6 = !v_s6 || h_free;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign vertices.ready = en1;

	// s1: differences
	logic signed [CW-1:0] p [4][3];
	logic signed [DW-1:0] fu_d [4][3], fv_d [4][3], ed_d [6][3];
	logic signed [DW-1:0] fu_s1 [4][3], fv_s1 [4][3], ed_s1 [6][3];

	always_comb begin
		p[0][0] = vertices.data.v0_x; p[0][1] = vertices.data.v0_y;
		p[0][2] = vertices.data.v0_z;
		p[1][0] = vertices.data.v1_x; p[1][1] = vertices.data.v1_y;
		p[1][2] = vertices.data.v1_z;
		p[2][0] = vertices.data.v2_x; p[2][1] = vertices.data.v2_y;
		p[2][2] = vertices.data.v2_z;
		p[3][0] = vertices.data.v3_x; p[3][1] = vertices.data.v3_y;
		p[3][2] = vertices.data.v3_z;
		for (int f = 0; f < 4; f++) begin
			for (int c = 0; c < 3; c++) begin
				fu_d[f][c] = DW'(p[FACE_TAB[f][1]][c]) - DW'(p[FACE_TAB[f][0]][c]);
				fv_d[f][c] = DW'(p[FACE_TAB[f][2]][c]) - DW'(p[FACE_TAB[f][0]][c]);
			end
		end
		for (int e = 0; e < 6; e++) begin
			for (int c = 0; c < 3; c++) begin
				ed_d[e][c] = DW'(p[PAIR_I[e]][c]) - DW'(p[PAIR_J[e]][c]);
			end
		end
	end

	// s2: cross product terms and squared differences
	logic signed [PW-1:0] x_d [4][6], x_s2 [4][6];
	logic [SQW-1:0]       sq_d [6][3], sq_s2 [6][3];
	logic signed [DW-1:0] e0_s2 [3];

	always_comb begin
		logic signed [PW-1:0] t;
		for (int f = 0; f < 4; f++) begin
			x_d[f][0] = fu_s1[f][1] * fv_s1[f][2];
			x_d[f][1] = fu_s1[f][2] * fv_s1[f][1];
			x_d[f][2] = fu_s1[f][2] * fv_s1[f][0];
			x_d[f][3] = fu_s1[f][0] * fv_s1[f][2];
			x_d[f][4] = fu_s1[f][0] * fv_s1[f][1];
			x_d[f][5] = fu_s1[f][1] * fv_s1[f][0];
		end
		for (int e = 0; e < 6; e++) begin
			for (int c = 0; c < 3; c++) begin
				t = ed_s1[e][c] * ed_s1[e][c];
				sq_d[e][c] = t[SQW-1:0];
			end
		end
	end

	// s3: normals and squared edge lengths
	logic signed [NW-1:0] n_d [4][3], n_s3 [4][3];
	logic [LW-1:0]        len_d [6], len_s3 [6];
	logic signed [DW-1:0] e0_s3 [3];

	always_comb begin
		for (int f = 0; f < 4; f++) begin
			n_d[f][0] = NW'(x_s2[f][0]) - NW'(x_s2[f][1]);
			n_d[f][1] = NW'(x_s2[f][2]) - NW'(x_s2[f][3]);
			n_d[f][2] = NW'(x_s2[f][4]) - NW'(x_s2[f][5]);
		end
		for (int e = 0; e < 6; e++) begin
			len_d[e] = LW'(sq_s2[e][0]) + LW'(sq_s2[e][1]) + LW'(sq_s2[e][2]);
		end
	end

	// s4: det partial products (det = -e0 . n1), first max level
	logic signed [DHW-1:0] pdh_d [3], pdh_s4 [3];
	logic signed [DLW-1:0] pdl_d [3], pdl_s4 [3];
	logic [LW-1:0]         mx_d [3], mx_s4 [3];
	logic signed [NW-1:0]  n_s4 [4][3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			pdh_d[c] = e0_s3[c] * $signed(n_s3[1][c][NW-1:NLW]);
			pdl_d[c] = e0_s3[c] * $signed({1'b0, n_s3[1][c][NLW-1:0]});
		end
		for (int m = 0; m < 3; m++) begin
			mx_d[m] = (len_s3[2*m] >= len_s3[2*m+1]) ? len_s3[2*m] : len_s3[2*m+1];
		end
	end

	// s5: det and h2
	logic signed [DETW-1:0] det_d, det_s5;
	logic [LW-1:0]          h2_d, h2_s5;
	logic signed [NW-1:0]   n_s5 [4][3];

	always_comb begin
		logic signed [DETW-1:0] acc;
		logic [LW-1:0]          m01;
		acc = '0;
		for (int c = 0; c < 3; c++) begin
			acc = acc + (DETW'(pdh_s4[c]) <<< NLW) + DETW'(pdl_s4[c]);
		end
		det_d = -acc;
		m01   = (mx_s4[0] >= mx_s4[1]) ? mx_s4[0] : mx_s4[1];
		h2_d  = (m01 >= mx_s4[2]) ? m01 : mx_s4[2];
	end

	// s6: weight products and denominator
	logic [DETW-1:0]      absdet;
	logic [DEN6W-1:0]     den6_d, den6_s6;
	logic [SPW-1:0]       sclh_d, scll_d, sclh_s6, scll_s6;
	logic                 degen_s6, detneg_s6;
	logic signed [NW-1:0] n_s6 [4][3];

	always_comb begin
		absdet = det_s5[DETW-1] ? -det_s5 : det_s5;
		den6_d = DEN6W'(absdet) * DEN6W'(DET_SCALE);
		sclh_d = delta_q * h2_s5[LW-1:HLW];
		scll_d = delta_q * h2_s5[HLW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
			v_s4 <= 1'b0; v_s5 <= 1'b0; v_s6 <= 1'b0;
		end else begin
			if (en1) v_s1 <= vertices.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			fu_s1 <= fu_d; fv_s1 <= fv_d; ed_s1 <= ed_d;
		end
		if (en2) begin
			x_s2 <= x_d; sq_s2 <= sq_d; e0_s2 <= fu_s1[2];
		end
		if (en3) begin
			n_s3 <= n_d; len_s3 <= len_d; e0_s3 <= e0_s2;
		end
		if (en4) begin
			pdh_s4 <= pdh_d; pdl_s4 <= pdl_d; mx_s4 <= mx_d; n_s4 <= n_s3;
		end
		if (en5) begin
			det_s5 <= det_d; h2_s5 <= h2_d; n_s5 <= n_s4;
		end
		if (en6) begin
			den6_s6   <= den6_d;
			sclh_s6   <= sclh_d;
			scll_s6   <= scll_d;
			degen_s6  <= (det_s5 == '0);
			detneg_s6 <= det_s5[DETW-1];
			n_s6      <= n_s5;
		end
	end

	// ---------------- hold register: sweeps the 16 entries ----------------
	logic [SCW-1:0]       hold_scale_q;
	logic [DEN6W-1:0]     hold_den6_q;
	logic                 hold_degen_q, hold_detneg_q;
	logic signed [NW-1:0] hold_n_q [4][3];
	logic                 out_valid_q;

	assign adv    = !out_valid_q || entries.ready;
	assign h_free = !h_valid_q || (adv && cnt_q == CNT_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_valid_q <= 1'b0;
			cnt_q     <= '0;
		end else if (h_free) begin
			h_valid_q <= v_s6;
			cnt_q     <= '0;
		end else if (adv) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (h_free) begin
			hold_scale_q  <= (SCW'(sclh_s6) << HLW) + SCW'(scll_s6);
			hold_den6_q   <= den6_s6;
			hold_degen_q  <= degen_s6;
			hold_detneg_q <= detneg_s6;
			hold_n_q      <= n_s6;
		end
	end

	// ---------------- back end: one entry per stage, frozen by adv ----------------
	logic v_s7, v_s8, v_s9, v_s10, v_s11, v_s12, v_s13;
	tpsm_meta_t meta_d, meta_s7, meta_s8, meta_s9, meta_s10, meta_s11, meta_s12, meta_s13;
	logic [SCW-1:0]   scale_s7, scale_s8, scale_s9;
	logic [DEN6W-1:0] den6_s7, den6_s8, den6_s9, den6_s10, den6_s11;

	// s7: dot product partials, normals split high/low
	logic signed [HHW-1:0]  hh_d [3], hh_s7 [3];
	logic signed [HLPW-1:0] hl_d [3], lh_d [3], hl_s7 [3], lh_s7 [3];
	logic [LLW-1:0]         ll_d [3], ll_s7 [3];

	always_comb begin
		logic signed [NW-1:0] ni, nj;
		meta_d.row   = cnt_q[CNT_W-1:2];
		meta_d.col   = cnt_q[1:0];
		meta_d.last  = (cnt_q == CNT_LAST);
		meta_d.degen = hold_degen_q;
		meta_d.neg   = hold_detneg_q;
		meta_d.big   = 1'b0;
		for (int c = 0; c < 3; c++) begin
			ni = hold_n_q[cnt_q[CNT_W-1:2]][c];
			nj = hold_n_q[cnt_q[1:0]][c];
			hh_d[c] = $signed(ni[NW-1:NLW]) * $signed(nj[NW-1:NLW]);
			hl_d[c] = $signed(ni[NW-1:NLW]) * $signed({1'b0, nj[NLW-1:0]});
			lh_d[c] = $signed(nj[NW-1:NLW]) * $signed({1'b0, ni[NLW-1:0]});
			ll_d[c] = ni[NLW-1:0] * nj[NLW-1:0];
		end
	end

	// s8: per-component products
	logic [PCW-1:0] pc_d [3], pc_s8 [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			pc_d[c] = (PCW'(hh_s7[c]) << (2*NLW))
				+ ((PCW'(hl_s7[c]) + PCW'(lh_s7[c])) << NLW)
				+ PCW'(ll_s7[c]);
		end
	end

	// s9: dot product, magnitude and sign of the entry
	logic [PCW-1:0]  dsum;
	logic [DOTW-1:0] dot, dneg;
	logic [ADW-1:0]  absdot_d, absdot_s9;
	tpsm_meta_t      meta9_d;

	always_comb begin
		dsum     = pc_s8[0] + pc_s8[1] + pc_s8[2];
		dot      = dsum[DOTW-1:0];
		dneg     = -dot;
		absdot_d = dot[DOTW-1] ? dneg[ADW-1:0] : dot[ADW-1:0];
		meta9_d  = meta_s8;
		meta9_d.neg = dot[DOTW-1] ^ meta_s8.neg;
	end

	// s10: numerator partial products, 32x32 limbs
	logic [PPW-1:0] pp_d [SCL][ADL], pp_s10 [SCL][ADL];

	always_comb begin
		logic [SCL*LIMB-1:0] sp;
		logic [ADL*LIMB-1:0] ap;
		sp = (SCL*LIMB)'(scale_s9);
		ap = (ADL*LIMB)'(absdot_s9);
		for (int a = 0; a < SCL; a++) begin
			for (int b = 0; b < ADL; b++) begin
				pp_d[a][b] = sp[a*LIMB +: LIMB] * ap[b*LIMB +: LIMB];
			end
		end
	end

	// s11: row sums
	logic [ROWW-1:0] row_d [SCL], row_s11 [SCL];

	always_comb begin
		for (int a = 0; a < SCL; a++) begin
			row_d[a] = '0;
			for (int b = 0; b < ADL; b++) begin
				row_d[a] = row_d[a] + (ROWW'(pp_s10[a][b]) << (LIMB*b));
			end
		end
	end

	// s12: dividend 2*num + den, divisor 2*den (rounds half away from zero)
	logic [NUMXW-1:0]  numx;
	logic [DENW-1:0]   den;
	logic [NUMERW-1:0] numer_d, numer_s12;
	logic [DIVW-1:0]   dv_d, dv_s12;

	always_comb begin
		numx = '0;
		for (int a = 0; a < SCL; a++) begin
			numx = numx + (NUMXW'(row_s11[a]) << (LIMB*a));
		end
		den     = DENW'(den6_s11) << FRAC;
		numer_d = {numx[NUMW-1:0], 1'b0} + NUMERW'(den);
		dv_d    = {den, 1'b0};
	end

	// s13: saturation check, divider seed
	logic [DIVW-1:0] rem_s13, dv_s13;
	logic [QW-1:0]   low_s13;
	tpsm_meta_t      meta13_d;

	always_comb begin
		meta13_d     = meta_s12;
		meta13_d.big = numer_s12 >= (NUMERW'(dv_s12) << QW);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0; v_s8 <= 1'b0; v_s9 <= 1'b0; v_s10 <= 1'b0;
			v_s11 <= 1'b0; v_s12 <= 1'b0; v_s13 <= 1'b0;
		end else if (adv) begin
			v_s7  <= h_valid_q;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hh_s7 <= hh_d; hl_s7 <= hl_d; lh_s7 <= lh_d; ll_s7 <= ll_d;
			meta_s7 <= meta_d; scale_s7 <= hold_scale_q; den6_s7 <= hold_den6_q;

			pc_s8 <= pc_d; meta_s8 <= meta_s7; scale_s8 <= scale_s7; den6_s8 <= den6_s7;

			absdot_s9 <= absdot_d; meta_s9 <= meta9_d;
			scale_s9 <= scale_s8; den6_s9 <= den6_s8;

			pp_s10 <= pp_d; meta_s10 <= meta_s9; den6_s10 <= den6_s9;

			row_s11 <= row_d; meta_s11 <= meta_s10; den6_s11 <= den6_s10;

			numer_s12 <= numer_d; dv_s12 <= dv_d; meta_s12 <= meta_s11;

			rem_s13  <= numer_s12[QW +: DIVW];
			low_s13  <= numer_s12[QW-1:0];
			dv_s13   <= dv_s12;
			meta_s13 <= meta13_d;
		end
	end

	logic            div_valid;
	logic [QW-1:0]   div_quo;
	tpsm_meta_t      div_meta;

	tpsm_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (v_s13),
		.in_rem    (rem_s13),
		.in_den    (dv_s13),
		.in_low    (low_s13),
		.in_meta   (meta_s13),
		.out_valid (div_valid),
		.out_quo   (div_quo),
		.out_meta  (div_meta)
	);

	// ---------------- output register ----------------
	tpsm_out_t      out_d, out_q;
	logic [VALW-1:0] mag;

	always_comb begin
		mag = VALW'(div_quo);
		out_d.row_index  = div_meta.row;
		out_d.col_index  = div_meta.col;
		out_d.degenerate = div_meta.degen;
		out_d.last_entry = div_meta.last;
		priority if (div_meta.degen) begin
			out_d.entry_value = '0;
		end else if (div_meta.big) begin
			out_d.entry_value = div_meta.neg ? VAL_MIN : VAL_MAX;
		end else begin
			out_d.entry_value = div_meta.neg ? -mag : mag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) out_q <= out_d;
	end

	assign entries.valid = out_valid_q;
	assign entries.data  = out_q;

	// ---------------- checks ----------------
	a_last_corner: assert property (@(posedge clk) disable iff (!arst_n)
		entries.valid && entries.data.last_entry
			|-> (&entries.data.row_index) && (&entries.data.col_index))
		else $error("last entry not at row 3, column 3");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		entries.valid && entries.data.degenerate |-> entries.data.entry_value == '0)
		else $error("degenerate entry is not zero");

	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		!h_valid_q |-> cnt_q == '0)
		else $error("entry counter moved without a held element");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		h_valid_q && !adv |=> h_valid_q && $stable(cnt_q))
		else $error("held element advanced during stall");

endmodule
